// ===== hw/rtl/cst_pkg.sv =====
// Shared types, character codes and reset values for the configuration statement tokenizer.
package cst_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 32;
    localparam int WORD_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [LINE_BITS-1:0]   t_line;
    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [7:0]             t_char;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_offset OFFSET_ONE = t_offset'(1);
    localparam t_line   LINE_ONE   = t_line'(1);

    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_HASH   = 8'h23;
    localparam t_char CH_SEMI   = 8'h3B;
    localparam t_char CH_EQ     = 8'h3D;
    localparam t_char CH_QUOTE  = 8'h22;
    localparam t_char CH_BSLASH = 8'h5C;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_CR     = 8'h0D;

    localparam t_cfg_idx CFG_BREAK_ON_EQUALS    = 2'd0;
    localparam t_cfg_idx CFG_BREAK_ON_SEMICOLON = 2'd1;
    localparam t_cfg_idx CFG_EQUALS_TIGHT       = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_DIR,
        PH_AFTER_EQ,
        PH_GAP1,
        PH_GAP2,
        PH_VSTART,
        PH_VALUE
    } t_phase;

    typedef struct packed {
        logic break_on_equals;
        logic break_on_semicolon;
        logic equals_tight;
    } t_cfg;

    typedef struct packed {
        t_offset pos;
        t_line   line_count;
        t_phase  phase;
        logic    in_comment;
        logic    in_quote;
        logic    escape_parity;
        t_offset line_begin;
        t_offset directive_begin;
        t_offset directive_finish;
        t_offset value_begin;
        t_offset value_trim_end;
        t_line   line_number;
        logic    equals_flag;
    } t_scan_state;

    typedef struct packed {
        t_word line_begin;
        t_word directive_begin;
        t_word directive_finish;
        t_word value_begin;
        t_word value_finish;
        t_word terminator_at;
        t_word line_number;
        logic  value_present;
        logic  equals_seen;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        break_on_equals:    1'b0,
        break_on_semicolon: 1'b0,
        equals_tight:       1'b0
    };

    localparam t_scan_state SCAN_RESET = '{
        pos:              '0,
        line_count:       LINE_ONE,
        phase:            PH_SKIP,
        in_comment:       1'b0,
        in_quote:         1'b0,
        escape_parity:    1'b0,
        line_begin:       '0,
        directive_begin:  '0,
        directive_finish: '0,
        value_begin:      '0,
        value_trim_end:   '0,
        line_number:      LINE_ONE,
        equals_flag:      1'b0
    };

    function automatic logic is_blank(t_char c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== hw/rtl/cst_step.sv =====
// Per-byte scan step: next scanner state and the statement result for one byte.
module cst_step (
    input  cst_pkg::t_scan_state i_state,
    input  cst_pkg::t_cfg        i_cfg,
    input  cst_pkg::t_char       i_byte,
    input  logic                 i_eot,
    output cst_pkg::t_scan_state o_next,
    output logic                 o_has_result,
    output cst_pkg::t_result     o_result
);

    function automatic cst_pkg::t_result make_result(
        cst_pkg::t_scan_state st,
        cst_pkg::t_offset     vb,
        cst_pkg::t_offset     ve,
        cst_pkg::t_offset     term,
        logic                 present
    );
        cst_pkg::t_result r;
        r.line_begin       = cst_pkg::t_word'(st.line_begin);
        r.directive_begin  = cst_pkg::t_word'(st.directive_begin);
        r.directive_finish = cst_pkg::t_word'(st.directive_finish);
        r.value_begin      = cst_pkg::t_word'(vb);
        r.value_finish     = cst_pkg::t_word'(ve);
        r.terminator_at    = cst_pkg::t_word'(term);
        r.line_number      = cst_pkg::t_word'(st.line_number);
        r.value_present    = present;
        r.equals_seen      = st.equals_flag;
        return r;
    endfunction

    // whitespace / comment / newline handling between statements, and start of a directive
    function automatic cst_pkg::t_scan_state skip_byte(
        cst_pkg::t_scan_state st,
        cst_pkg::t_char       c,
        logic                 semi,
        cst_pkg::t_offset     p1,
        cst_pkg::t_line       lc1
    );
        cst_pkg::t_scan_state r;
        r = st;
        if (c == cst_pkg::CH_HASH) begin
            r.in_comment = 1'b1;
        end else if (c == cst_pkg::CH_NL) begin
            r.in_comment = 1'b0;
            r.line_count = lc1;
            r.line_begin = p1;
        end else if (cst_pkg::is_blank(c) || st.in_comment || semi) begin
            r.in_comment = st.in_comment;
        end else begin
            r.line_number     = st.line_count;
            r.directive_begin = st.pos;
            r.equals_flag     = 1'b0;
            r.phase           = cst_pkg::PH_DIR;
        end
        return r;
    endfunction

    cst_pkg::t_scan_state s;
    cst_pkg::t_result     res;
    cst_pkg::t_offset     p;
    cst_pkg::t_offset     p1;
    cst_pkg::t_line       lc1;
    logic                 hit;
    logic                 go;
    logic                 blk;
    logic                 nl;
    logic                 hash;
    logic                 semi;
    logic                 eq;
    logic                 quote;
    logic                 stop;

    always_comb begin
        s     = i_state;
        p     = i_state.pos;
        p1    = i_state.pos + cst_pkg::OFFSET_ONE;
        lc1   = i_state.line_count + cst_pkg::LINE_ONE;
        blk   = cst_pkg::is_blank(i_byte);
        nl    = (i_byte == cst_pkg::CH_NL);
        hash  = (i_byte == cst_pkg::CH_HASH);
        semi  = i_cfg.break_on_semicolon && (i_byte == cst_pkg::CH_SEMI);
        eq    = (i_byte == cst_pkg::CH_EQ);
        quote = (i_byte == cst_pkg::CH_QUOTE);
        hit   = 1'b0;
        go    = 1'b1;
        stop  = 1'b0;
        res   = '0;

        if (s.phase == cst_pkg::PH_SKIP) begin
            s  = skip_byte(s, i_byte, semi, p1, lc1);
            go = (s.phase == cst_pkg::PH_DIR);
        end

        if (go && s.phase == cst_pkg::PH_DIR) begin
            if (blk || semi) begin
                s.directive_finish = p;
                s.phase            = cst_pkg::PH_GAP1;
            end else if (i_cfg.break_on_equals && eq) begin
                s.equals_flag      = 1'b1;
                s.directive_finish = p;
                s.phase            = cst_pkg::PH_AFTER_EQ;
                go                 = 1'b0;
            end else begin
                go = 1'b0;
            end
        end

        if (go && s.phase == cst_pkg::PH_AFTER_EQ) begin
            if (i_cfg.equals_tight && blk && !nl) begin
                res          = make_result(s, p, p, p, 1'b0);
                hit          = 1'b1;
                s.phase      = cst_pkg::PH_SKIP;
                s.in_comment = 1'b0;
                s.line_begin = p;
            end else begin
                s.phase = cst_pkg::PH_GAP1;
            end
        end

        if (go && s.phase == cst_pkg::PH_GAP1) begin
            if (blk && !nl) begin
                go = 1'b0;
            end else if (i_cfg.break_on_equals && !i_cfg.equals_tight && eq) begin
                s.equals_flag = 1'b1;
                s.phase       = cst_pkg::PH_GAP2;
                go            = 1'b0;
            end else begin
                s.phase = cst_pkg::PH_VSTART;
            end
        end

        if (go && s.phase == cst_pkg::PH_GAP2) begin
            if (!(blk && !nl)) begin
                s.phase = cst_pkg::PH_VSTART;
            end else begin
                go = 1'b0;
            end
        end

        if (go && s.phase == cst_pkg::PH_VSTART) begin
            if (nl || hash || semi) begin
                res          = make_result(s, p, p, p, 1'b0);
                hit          = 1'b1;
                s.phase      = cst_pkg::PH_SKIP;
                s.in_comment = 1'b0;
                s.line_begin = p;
            end else begin
                s.value_begin    = p;
                s.value_trim_end = p;
                s.in_quote       = 1'b0;
                s.escape_parity  = 1'b0;
                s.phase          = cst_pkg::PH_VALUE;
            end
        end

        if (go && s.phase == cst_pkg::PH_VALUE) begin
            if (quote || hash || nl || semi) begin
                if (s.escape_parity) begin
                    if (nl) begin
                        s.line_count = lc1;
                    end
                end else if (quote) begin
                    s.in_quote = !s.in_quote;
                end else if (nl) begin
                    stop = 1'b1;
                end else if (!s.in_quote) begin
                    stop = 1'b1;
                end
            end
            if (stop) begin
                res          = make_result(s, s.value_begin, s.value_trim_end, p, 1'b1);
                hit          = 1'b1;
                s.phase      = cst_pkg::PH_SKIP;
                s.in_comment = 1'b0;
                s.line_begin = p;
            end else begin
                if (!blk) begin
                    s.value_trim_end = p1;
                end
                s.escape_parity = (i_byte == cst_pkg::CH_BSLASH) ? !s.escape_parity : 1'b0;
                go              = 1'b0;
            end
        end

        // terminator byte is rescanned as skippable text
        if (go && hit && s.phase == cst_pkg::PH_SKIP) begin
            s = skip_byte(s, i_byte, semi, p1, lc1);
        end

        if (i_eot) begin
            if (!hit && s.phase != cst_pkg::PH_SKIP) begin
                if (s.phase == cst_pkg::PH_VALUE) begin
                    res = make_result(s, s.value_begin, s.value_trim_end, p1, 1'b1);
                end else begin
                    if (s.phase == cst_pkg::PH_DIR) begin
                        s.directive_finish = p1;
                    end
                    res = make_result(s, p1, p1, p1, 1'b0);
                end
                hit = 1'b1;
            end
            s = cst_pkg::SCAN_RESET;
        end else begin
            s.pos = p1;
        end

        o_next       = s;
        o_has_result = hit;
        o_result     = res;
    end

endmodule

// ===== hw/rtl/config_statement_tokenizer_core.sv =====
// Top level of the configuration statement tokenizer: state, config registers and result buffer.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  text in   | i_in_valid / o_in_ready | i_text_byte, i_end_of_text
//  result out| o_out_valid/i_out_ready | o_line_begin .. o_equals_seen
//  config    | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_ready is high; the scan step is a single combinational pass
// into the state registers, and each result is registered in the output or skid register.
// Result register plus one skid entry: o_in_ready is registered and drops only when both hold
// results, so a stalled consumer costs no input cycles until the second result.
// Synchronous active-low reset; no clearing pass.
module config_statement_tokenizer_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_line_begin,
    output logic [31:0]           o_directive_begin,
    output logic [31:0]           o_directive_finish,
    output logic [31:0]           o_value_begin,
    output logic [31:0]           o_value_finish,
    output logic [31:0]           o_terminator_at,
    output logic [31:0]           o_line_number,
    output logic                  o_value_present,
    output logic                  o_equals_seen,
    input  logic                  i_cfg_we,
    input  cst_pkg::t_cfg_idx     i_cfg_index,
    input  logic                  i_cfg_data
);

    cst_pkg::t_cfg        r_cfg;
    cst_pkg::t_cfg        n_cfg;
    cst_pkg::t_scan_state r_state;
    cst_pkg::t_scan_state step_next;
    logic                 step_hit;
    cst_pkg::t_result     step_res;
    cst_pkg::t_result     r_out;
    cst_pkg::t_result     n_out;
    cst_pkg::t_result     r_skid;
    cst_pkg::t_result     n_skid;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    logic                 in_beat;
    logic                 out_beat;
    logic                 push;

    cst_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_byte       (i_text_byte),
        .i_eot        (i_end_of_text),
        .o_next       (step_next),
        .o_has_result (step_hit),
        .o_result     (step_res)
    );

    assign o_in_ready = !r_skid_valid;
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_beat   = r_out_valid && i_out_ready;
    assign push       = in_beat && step_hit;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                cst_pkg::CFG_BREAK_ON_EQUALS:    n_cfg.break_on_equals    = i_cfg_data;
                cst_pkg::CFG_BREAK_ON_SEMICOLON: n_cfg.break_on_semicolon = i_cfg_data;
                cst_pkg::CFG_EQUALS_TIGHT:       n_cfg.equals_tight       = i_cfg_data;
                default:                         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_beat) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_beat) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = step_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_beat) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= cst_pkg::CFG_RESET;
            r_state      <= cst_pkg::SCAN_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_cfg        <= n_cfg;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (in_beat) begin
                r_state <= step_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid        = r_out_valid;
    assign o_line_begin       = r_out.line_begin;
    assign o_directive_begin  = r_out.directive_begin;
    assign o_directive_finish = r_out.directive_finish;
    assign o_value_begin      = r_out.value_begin;
    assign o_value_finish     = r_out.value_finish;
    assign o_terminator_at    = r_out.terminator_at;
    assign o_line_number      = r_out.line_number;
    assign o_value_present    = r_out.value_present;
    assign o_equals_seen      = r_out.equals_seen;

endmodule

// ===== hw/rtl/cst_checker.sv =====
// Port-level checker for the configuration statement tokenizer, bound to the top level.
module cst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [31:0]       o_value_begin,
    input logic [31:0]       o_value_finish,
    input logic [31:0]       o_terminator_at,
    input logic [31:0]       o_line_number,
    input logic              o_value_present
);

    // result beat stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_terminator_at) && $stable(o_value_begin) && $stable(o_line_number))
        else $error("stalled result beat changed");

    // a full skid stage implies a pending result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // no value: empty value span sitting at the terminator
    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_value_present |->
            (o_value_begin == o_value_finish) && (o_value_begin == o_terminator_at))
        else $error("statement without value has a nonempty value span");

    // the stage frees as soon as the waiting result leaves
    a_ready_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && i_out_ready |=> o_in_ready)
        else $error("input stall outlasted the result beat");

endmodule

bind config_statement_tokenizer_core cst_checker u_cst_checker (.*);
